[src/bsf_pkg.sv]
// bsf_pkg: types and constants shared by the byte stuffing framer
// no dependencies; compile first
package bsf_pkg;

    localparam int MAX_RUN   = 9;
    localparam int RUN_CNT_W = 4;
    localparam int CFG_IDX_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FLAG       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLAG_SUB   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_SUB = 3'd4;

    // reset values of the registers
    localparam logic [7:0] RST_FLAG       = 8'd126;
    localparam logic [7:0] RST_ADDRESS    = 8'd3;
    localparam logic [7:0] RST_ESCAPE     = 8'd125;
    localparam logic [7:0] RST_FLAG_SUB   = 8'd94;
    localparam logic [7:0] RST_ESCAPE_SUB = 8'd93;

    typedef struct packed {
        logic [7:0] flag_value;
        logic [7:0] address_value;
        logic [7:0] escape_value;
        logic [7:0] flag_substitute;
        logic [7:0] escape_substitute;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] ctrl_byte;
        logic       first_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] value;
        logic       frame_end;
    } entry_t;

    typedef struct packed {
        logic [RUN_CNT_W-1:0]      count;
        entry_t [MAX_RUN-1:0]      entries;
    } run_t;

    typedef struct packed {
        logic [7:0] check_acc;
        logic       inside_frame;
    } frame_state_t;

    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } stuffed_t;

    // escape rule: flag test wins over escape test
    function automatic stuffed_t stuff_byte(input logic [7:0] b, input cfg_t cfg);
        stuffed_t s;
        s.two = 1'b0;
        s.b0  = b;
        s.b1  = cfg.escape_substitute;
        if (b == cfg.flag_value)
        begin
            s.two = 1'b1;
            s.b0  = cfg.escape_value;
            s.b1  = cfg.flag_substitute;
        end
        else if (b == cfg.escape_value)
        begin
            s.two = 1'b1;
            s.b0  = cfg.escape_value;
            s.b1  = cfg.escape_substitute;
        end
        return s;
    endfunction

endpackage

[src/bsf_chan_if.sv]
// bsf_chan_if: valid/ready channels for payload beats in and framed bytes out
// no dependencies
interface bsf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] ctrl_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output ctrl_byte,
                    output first_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input ctrl_byte,
                    input first_byte, input last_byte, output ready);
endinterface

interface bsf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;
    logic       frame_end;

    modport source (output valid, output out_byte, output run_end,
                    output frame_end, input ready);
    modport sink   (input valid, input out_byte, input run_end,
                    input frame_end, output ready);
endinterface

[src/bsf_encoder.sv]
// bsf_encoder: builds the whole byte run for one payload beat and the next frame state
// depends on bsf_pkg
module bsf_encoder
    import bsf_pkg::*;
(
    input  item_t        item,
    input  frame_state_t state,
    input  cfg_t         cfg,
    output run_t         run,
    output frame_state_t state_next
);

    always_comb
    begin
        logic [RUN_CNT_W-1:0] idx;
        logic [7:0]           acc_new;
        stuffed_t             s;

        run        = '0;
        idx        = '0;
        state_next = state;
        acc_new    = state.check_acc ^ item.data_byte;

        // header, sent without stuffing
        if (item.first_byte)
        begin
            run.entries[0] = '{value: cfg.flag_value, frame_end: 1'b0};
            run.entries[1] = '{value: cfg.address_value, frame_end: 1'b0};
            run.entries[2] = '{value: item.ctrl_byte, frame_end: 1'b0};
            run.entries[3] = '{value: item.ctrl_byte ^ cfg.address_value,
                               frame_end: 1'b0};
            idx     = RUN_CNT_W'(4);
            acc_new = item.data_byte;
        end

        if (item.first_byte || state.inside_frame)
        begin
            s = stuff_byte(item.data_byte, cfg);
            run.entries[idx] = '{value: s.b0, frame_end: 1'b0};
            if (s.two)
            begin
                run.entries[idx + 4'd1] = '{value: s.b1, frame_end: 1'b0};
                idx = idx + 4'd2;
            end
            else
            begin
                idx = idx + 4'd1;
            end

            if (item.last_byte)
            begin
                // bcc2 stuffed, then closing flag
                s = stuff_byte(acc_new, cfg);
                run.entries[idx] = '{value: s.b0, frame_end: 1'b0};
                if (s.two)
                begin
                    run.entries[idx + 4'd1] = '{value: s.b1, frame_end: 1'b0};
                    idx = idx + 4'd2;
                end
                else
                begin
                    idx = idx + 4'd1;
                end
                run.entries[idx] = '{value: cfg.flag_value, frame_end: 1'b1};
                idx = idx + 4'd1;
                state_next.check_acc    = '0;
                state_next.inside_frame = 1'b0;
            end
            else
            begin
                state_next.check_acc    = acc_new;
                state_next.inside_frame = 1'b1;
            end
        end
        else
        begin
            // dropped beat outside a frame
            s = stuff_byte(item.data_byte, cfg);
        end

        run.count = idx;
    end

endmodule

[src/bsf_run_buffer.sv]
// bsf_run_buffer: holds one byte run and shifts it into the output register
// depends on bsf_pkg and bsf_out_if
module bsf_run_buffer
    import bsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  run_t       run,
    output logic       can_load,
    bsf_out_if.source  out_chan
);

    entry_t [MAX_RUN-1:0]  entries_reg, entries_next;
    logic [RUN_CNT_W-1:0]  left_reg, left_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg;
    logic                  run_end_reg;
    logic                  frame_end_reg;
    logic                  move;

    assign move     = (left_reg != '0) && (!out_valid_reg || out_chan.ready);
    assign can_load = (left_reg == '0) || ((left_reg == 4'd1) && move);

    always_comb
    begin
        entries_next = entries_reg;
        left_next    = left_reg;
        if (move)
        begin
            for (int i = 0; i < MAX_RUN - 1; i++)
            begin
                entries_next[i] = entries_reg[i + 1];
            end
            left_next = left_reg - 4'd1;
        end
        if (load)
        begin
            entries_next = run.entries;
            left_next    = run.count;
        end
    end

    assign out_valid_next = move || (out_valid_reg && !out_chan.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
        if (move)
        begin
            out_byte_reg  <= entries_reg[0].value;
            frame_end_reg <= entries_reg[0].frame_end;
            run_end_reg   <= (left_reg == 4'd1);
        end
    end

    assign out_chan.valid     = out_valid_reg;
    assign out_chan.out_byte  = out_byte_reg;
    assign out_chan.run_end   = run_end_reg;
    assign out_chan.frame_end = frame_end_reg;

endmodule

[src/byte_stuffing_framer_core.sv]
// byte_stuffing_framer_core: top level of the transmit framer
// depends on bsf_pkg, bsf_chan_if, bsf_encoder and bsf_run_buffer

// hdlc-style transmit framer. each payload beat on in_chan comes with first/last
// marks and a control byte; a first beat opens a frame with flag, address,
// control and control^address, every payload byte is escaped (flag -> escape +
// flag substitute, escape -> escape + escape substitute), and a last beat adds
// the escaped xor check byte and the closing flag. one beat makes 0 to 9 output
// bytes; out_chan carries one byte per cycle while ready stays high, so a plain
// middle byte makes one output byte and an escaped one makes two. the input
// register, the encoder and the run buffer overlap, so the next beat is taken in
// the same cycle the last byte of the current run moves to the output register.
// an accepted beat passes the input register and the run buffer before its first
// byte reaches the output register. beats arriving with first_byte low outside a
// frame are swallowed without output. config registers are written through cfg_wr_en /
// cfg_index / cfg_wdata; the user must write them only while the block is idle,
// which the block itself does not enforce; indexes past the last register are ignored.
module byte_stuffing_framer_core
    import bsf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    bsf_in_if.sink               in_chan,
    bsf_out_if.source            out_chan,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata
);

    // config registers
    cfg_t          cfg_reg, cfg_next;

    // input register
    logic          in_valid_reg, in_valid_next;
    item_t         item_reg;

    // frame state: running check byte and open-frame mark
    frame_state_t  state_reg, state_next;
    frame_state_t  enc_state;
    run_t          enc_run;

    logic          can_load;
    logic          load;
    logic          take_in;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FLAG:       cfg_next.flag_value        = cfg_wdata;
                REG_ADDRESS:    cfg_next.address_value     = cfg_wdata;
                REG_ESCAPE:     cfg_next.escape_value      = cfg_wdata;
                REG_FLAG_SUB:   cfg_next.flag_substitute   = cfg_wdata;
                REG_ESCAPE_SUB: cfg_next.escape_substitute = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // beat handshake: input register frees when its run can be loaded
    assign load          = in_valid_reg && can_load;
    assign in_chan.ready = !in_valid_reg || can_load;
    assign take_in       = in_chan.valid && in_chan.ready;
    assign in_valid_next = take_in || (in_valid_reg && !can_load);
    assign state_next    = load ? enc_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_value        <= RST_FLAG;
            cfg_reg.address_value     <= RST_ADDRESS;
            cfg_reg.escape_value      <= RST_ESCAPE;
            cfg_reg.flag_substitute   <= RST_FLAG_SUB;
            cfg_reg.escape_substitute <= RST_ESCAPE_SUB;
            in_valid_reg              <= 1'b0;
            state_reg                 <= '0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_reg.data_byte  <= in_chan.data_byte;
            item_reg.ctrl_byte  <= in_chan.ctrl_byte;
            item_reg.first_byte <= in_chan.first_byte;
            item_reg.last_byte  <= in_chan.last_byte;
        end
    end

    // whole run for the held beat in one pass
    bsf_encoder u_encoder
    (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .run        (enc_run),
        .state_next (enc_state)
    );

    // run storage and output register
    bsf_run_buffer u_run_buffer
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .run      (enc_run),
        .can_load (can_load),
        .out_chan (out_chan)
    );

endmodule

[sim/byte_stuffing_framer_core_tb.sv]
`timescale 1ns / 1ps
// byte_stuffing_framer_core_tb: self-checking bench for the byte stuffing framer
// depends on bsf_pkg, bsf_chan_if and byte_stuffing_framer_core; predicts every
// framed byte from the payload beats and checks the output stream against it
module byte_stuffing_framer_core_tb
    import bsf_pkg::*;
();

    // one byte of the framed stream as it should leave out_chan
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       frame_end;
    } framed_byte_t;

    // framed beats per random phase; with the directed tests and stray beats
    // five phases give about 480 beats
    localparam int FRAMED_PER_PHASE = 90;
    // quiet cycles after the last byte before a register write; covers the
    // input register and run buffer plus a dropped beat still in flight
    localparam int DRAIN_CYCLES     = 12;
    localparam int MAX_REPORTS      = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_wdata;

    bsf_in_if  in_chan ();
    bsf_out_if out_chan ();

    byte_stuffing_framer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_chan   (in_chan),
        .out_chan  (out_chan),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // bench copy of the register file and of the frame state
    cfg_t       shadow_cfg;
    logic [7:0] bcc_acc;
    logic       frame_open;

    // bytes still owed by the framer, oldest first
    framed_byte_t expected_bytes[$];
    // bytes made by the beat being predicted
    framed_byte_t beat_bytes[$];

    // random idling on both channels; cleared for the last phase
    bit idle_en;

    int beats_accepted = 0;
    int beats_framed   = 0;
    int beats_dropped  = 0;
    int frames_closed  = 0;
    int bytes_checked  = 0;
    int mismatch_count = 0;

    // 4 ns clock, low at time zero
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // framing predictor
    // ------------------------------------------------------------------

    function automatic void add_byte(input logic [7:0] b, input logic closing);
        framed_byte_t fb;
        fb.out_byte  = b;
        fb.run_end   = 1'b0;
        fb.frame_end = closing;
        beat_bytes.push_back(fb);
    endfunction

    // escaping: the flag test is made first, so with flag equal to escape
    // such a byte always goes out as escape plus flag substitute
    function automatic void add_escaped(input logic [7:0] b);
        if (b == shadow_cfg.flag_value)
        begin
            add_byte(shadow_cfg.escape_value, 1'b0);
            add_byte(shadow_cfg.flag_substitute, 1'b0);
        end
        else if (b == shadow_cfg.escape_value)
        begin
            add_byte(shadow_cfg.escape_value, 1'b0);
            add_byte(shadow_cfg.escape_substitute, 1'b0);
        end
        else
        begin
            add_byte(b, 1'b0);
        end
    endfunction

    // expected bytes of one accepted beat, queued behind earlier ones
    function automatic void frame_beat(input item_t it);
        framed_byte_t fb;
        beat_bytes.delete();
        // a first beat always opens a fresh frame, abandoning any open one
        if (it.first_byte)
        begin
            add_byte(shadow_cfg.flag_value, 1'b0);
            add_byte(shadow_cfg.address_value, 1'b0);
            add_byte(it.ctrl_byte, 1'b0);
            add_byte(it.ctrl_byte ^ shadow_cfg.address_value, 1'b0);
            bcc_acc    = 8'h00;
            frame_open = 1'b1;
        end
        if (!frame_open)
        begin
            // beat outside a frame is swallowed, even with last_byte set
            beats_dropped++;
            return;
        end
        add_escaped(it.data_byte);
        bcc_acc = bcc_acc ^ it.data_byte;
        if (it.last_byte)
        begin
            add_escaped(bcc_acc);
            add_byte(shadow_cfg.flag_value, 1'b1);
            frame_open = 1'b0;
            bcc_acc    = 8'h00;
            frames_closed++;
        end
        fb = beat_bytes.pop_back();
        fb.run_end = 1'b1;
        beat_bytes.push_back(fb);
        foreach (beat_bytes[i])
            expected_bytes.push_back(beat_bytes[i]);
        beats_framed++;
    endfunction

    // ------------------------------------------------------------------
    // drivers, called at the falling edge and returning at one
    // ------------------------------------------------------------------

    // write one register; indexes past the register list leave all unchanged
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            REG_FLAG:       shadow_cfg.flag_value        = val;
            REG_ADDRESS:    shadow_cfg.address_value     = val;
            REG_ESCAPE:     shadow_cfg.escape_value      = val;
            REG_FLAG_SUB:   shadow_cfg.flag_substitute   = val;
            REG_ESCAPE_SUB: shadow_cfg.escape_substitute = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // all five registers plus one write to an unused index
    task automatic load_config(input cfg_t c);
        logic [CFG_IDX_W-1:0] unused_idx;
        unused_idx = CFG_IDX_W'(REG_ESCAPE_SUB + 1 + $urandom_range(0, 2));
        write_reg(REG_FLAG, c.flag_value);
        write_reg(REG_ADDRESS, c.address_value);
        write_reg(unused_idx, 8'($urandom_range(0, 255)));
        write_reg(REG_ESCAPE, c.escape_value);
        write_reg(REG_FLAG_SUB, c.flag_substitute);
        write_reg(REG_ESCAPE_SUB, c.escape_substitute);
    endtask

    // present one beat, hold it until taken, predict its bytes; valid stays
    // high on return so back-to-back beats need no gap
    task automatic send_beat(input logic [7:0] data, input logic [7:0] ctrl,
                             input logic first, input logic last);
        item_t it;
        it.data_byte  = data;
        it.ctrl_byte  = ctrl;
        it.first_byte = first;
        it.last_byte  = last;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_chan.valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_chan.valid      = 1'b1;
        in_chan.data_byte  = it.data_byte;
        in_chan.ctrl_byte  = it.ctrl_byte;
        in_chan.first_byte = it.first_byte;
        in_chan.last_byte  = it.last_byte;
        @(posedge clk);
        while (!in_chan.ready)
            @(posedge clk);
        frame_beat(it);
        beats_accepted++;
        @(negedge clk);
    endtask

    // drop valid and let the framer empty before touching registers
    task automatic wait_idle();
        in_chan.valid = 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // payload byte that often hits the flag or escape codes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return shadow_cfg.flag_value;
            1:       return shadow_cfg.escape_value;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one frame of 1 to 8 beats; an unfinished one is left open to be
    // abandoned by the next first beat
    task automatic send_random_frame(input bit unfinished);
        int len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            send_beat(pick_byte(), pick_byte(), i == 0, (i == len - 1) && !unfinished);
    endtask

    // ------------------------------------------------------------------
    // output side: random stall bursts and the byte checker
    // ------------------------------------------------------------------

    initial
    begin : out_ready_drive
        int stall_left;
        stall_left     = 0;
        out_chan.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_chan.ready = 1'b0;
                stall_left--;
            end
            else if (idle_en && $urandom_range(0, 4) == 0)
            begin
                out_chan.ready = 1'b0;
                stall_left     = $urandom_range(0, 6);
            end
            else
            begin
                out_chan.ready = 1'b1;
            end
        end
    end

    function automatic void report_mismatch(input string what, input framed_byte_t want,
                                            input framed_byte_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: %s: expected byte %02h run_end %0b frame_end %0b,",
                      " got byte %02h run_end %0b frame_end %0b"},
                     $realtime, what, want.out_byte, want.run_end, want.frame_end,
                     got.out_byte, got.run_end, got.frame_end);
    endfunction

    // every byte taken on out_chan is matched against the oldest expectation
    always @(posedge clk)
    begin : byte_check
        framed_byte_t got;
        framed_byte_t want;
        if (rst_n && out_chan.valid && out_chan.ready)
        begin
            got.out_byte  = out_chan.out_byte;
            got.run_end   = out_chan.run_end;
            got.frame_end = out_chan.frame_end;
            bytes_checked++;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch("byte with none expected", '0, got);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (got.out_byte !== want.out_byte || got.run_end !== want.run_end
                    || got.frame_end !== want.frame_end)
                    report_mismatch("byte mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset register values: one-beat frame, escaped payload, check byte
    // that equals flag or escape
    task automatic test_default_frames();
        send_beat(8'h42, 8'h00, 1'b1, 1'b1);
        // flag and escape in the payload, control at its top value
        send_beat(RST_FLAG, 8'hFF, 1'b1, 1'b0);
        send_beat(RST_ESCAPE, 8'h00, 1'b0, 1'b0);
        send_beat(8'hFF, 8'h00, 1'b0, 1'b0);
        send_beat(8'h00, 8'h00, 1'b0, 1'b1);
        // control equal to flag stays unescaped in the header
        send_beat(RST_FLAG, RST_FLAG, 1'b1, 1'b1);
        send_beat(RST_ESCAPE, RST_ESCAPE, 1'b1, 1'b1);
    endtask

    // beats outside a frame, and a frame cut short by a new first beat
    task automatic test_idle_and_abandon();
        send_beat(8'h5A, 8'hA5, 1'b0, 1'b1);
        send_beat(8'hC3, 8'h3C, 1'b0, 1'b0);
        send_beat(8'h11, 8'h01, 1'b1, 1'b0);
        send_beat(8'h22, 8'h02, 1'b0, 1'b0);
        send_beat(8'h33, 8'h80, 1'b1, 1'b0);
        send_beat(8'h44, 8'h04, 1'b0, 1'b1);
    endtask

    // register extremes, flag equal to escape, writes to unused indexes
    task automatic test_register_extremes();
        cfg_t c;
        wait_idle();
        // all zero: flag and escape collide, flag rule wins
        c = '0;
        load_config(c);
        send_beat(8'h00, 8'h00, 1'b1, 1'b1);
        wait_idle();
        // all ones
        c = '1;
        load_config(c);
        send_beat(8'hFF, 8'hFF, 1'b1, 1'b0);
        send_beat(8'h00, 8'h00, 1'b0, 1'b1);
        wait_idle();
        // flag at zero, escape at top, mixed substitutes
        c.flag_value        = 8'h00;
        c.address_value     = 8'hA5;
        c.escape_value      = 8'hFF;
        c.flag_substitute   = 8'h5A;
        c.escape_substitute = 8'hC3;
        load_config(c);
        send_beat(8'hFF, 8'h5A, 1'b1, 1'b0);
        send_beat(8'h00, 8'h00, 1'b0, 1'b1);
    endtask

    // one random phase under one register setting; mostly whole frames,
    // some unfinished ones and some stray beats between frames
    task automatic run_random_phase(input cfg_t c);
        int start_count;
        wait_idle();
        load_config(c);
        start_count = beats_framed;
        while (beats_framed - start_count < FRAMED_PER_PHASE)
        begin
            case ($urandom_range(0, 9))
                0: send_beat(pick_byte(), pick_byte(), 1'b0, 1'($urandom_range(0, 1)));
                1: send_random_frame(1'b1);
                default: send_random_frame(1'b0);
            endcase
        end
        // leave the phase with no frame open
        if (frame_open)
            send_beat(pick_byte(), pick_byte(), 1'b0, 1'b1);
    endtask

    task automatic test_random_phases();
        cfg_t c;
        byte unsigned shared;
        c = {RST_FLAG, RST_ADDRESS, RST_ESCAPE, RST_FLAG_SUB, RST_ESCAPE_SUB};
        run_random_phase(c);
        c = cfg_t'({$urandom, 8'($urandom)});
        run_random_phase(c);
        c.flag_value        = 8'h00;
        c.address_value     = 8'h00;
        c.escape_value      = 8'hFF;
        c.flag_substitute   = 8'hFF;
        c.escape_substitute = 8'h00;
        run_random_phase(c);
        shared = 8'($urandom_range(0, 255));
        c = cfg_t'({$urandom, 8'($urandom)});
        c.flag_value   = shared;
        c.escape_value = shared;
        run_random_phase(c);
        // closing stretch runs at full rate on both sides
        idle_en = 1'b0;
        c = cfg_t'({$urandom, 8'($urandom)});
        run_random_phase(c);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = REG_FLAG;
        cfg_wdata          = 8'h00;
        in_chan.valid      = 1'b0;
        in_chan.data_byte  = 8'h00;
        in_chan.ctrl_byte  = 8'h00;
        in_chan.first_byte = 1'b0;
        in_chan.last_byte  = 1'b0;
        idle_en            = 1'b1;
        shadow_cfg = {RST_FLAG, RST_ADDRESS, RST_ESCAPE, RST_FLAG_SUB, RST_ESCAPE_SUB};
        bcc_acc    = 8'h00;
        frame_open = 1'b0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_default_frames();
        test_idle_and_abandon();
        test_register_extremes();
        test_random_phases();

        // everything sent; let the last bytes out and watch for strays
        wait_idle();

        $display("run covered %0d beats (%0d swallowed outside a frame), %0d closed frames",
                 beats_accepted, beats_dropped, frames_closed);
        $display("%0d framed bytes checked over eight register settings, %0d mismatches",
                 bytes_checked, mismatch_count);
        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("watchdog expired with %0d bytes outstanding", expected_bytes.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/bsf_pkg.sv
src/bsf_chan_if.sv
src/bsf_encoder.sv
src/bsf_run_buffer.sv
src/byte_stuffing_framer_core.sv
sim/byte_stuffing_framer_core_tb.sv
